[hdl/awm_pkg.sv]
// ----------------------------------------------------------------------------
// awm_pkg: shared types for the anagram window matcher
// Input mode codes, the operation carried down the cell chain, and the item
// record that every cell hands to its neighbor.
// ----------------------------------------------------------------------------
package awm_pkg;

    localparam int LETTER_W = 5;
    localparam int MODE_W   = 2;
    localparam int MATCH_W  = 32;
    localparam int DELTA_W  = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_PATTERN = 2'd1,
        MODE_TEXT    = 2'd2
    } awm_mode_t;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_PATTERN = 2'd2,
        OP_TEXT    = 2'd3
    } awm_op_t;

    // one item in flight along the chain
    typedef struct packed {
        awm_op_t                    op;
        logic [LETTER_W-1:0]        letter;
        logic [LETTER_W-1:0]        old_letter;
        logic                       remove;
        logic                       eligible;
        logic [MATCH_W-1:0]         start;
        logic signed [DELTA_W-1:0]  delta;
    } awm_item_t;

endpackage

[hdl/awm_head.sv]
// ----------------------------------------------------------------------------
// awm_head: input decode, pattern length, position counter and letter ring
// Turns an accepted item into a chain operation and fetches the letter that
// leaves the window from the ring of recent text letters.
// ----------------------------------------------------------------------------
module awm_head
    import awm_pkg::*;
#(
    parameter int MAX_PATTERN   = 256,
    parameter int ALPHABET      = 26,
    parameter int POSITION_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                advance,
    input  logic [MODE_W-1:0]   mode,
    input  logic [LETTER_W-1:0] letter,
    output awm_item_t           item_out
);

    localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
    localparam int RING_AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SUM_W   = LEN_W + 1;
    localparam int CMP_W   = (POSITION_BITS + 1 > LEN_W) ? POSITION_BITS + 1 : LEN_W;

    logic [LETTER_W-1:0]      ring_mem [0:MAX_PATTERN-1];
    logic [LETTER_W-1:0]      rd_data_reg;
    logic [POSITION_BITS-1:0] pos_reg,  pos_next;
    logic [LEN_W-1:0]         len_reg,  len_next;
    logic [RING_AW-1:0]       ptr_reg,  ptr_next;
    awm_item_t                item_reg, item_next;

    logic [SUM_W-1:0]   rd_sum;
    logic [RING_AW-1:0] rd_addr;
    logic [CMP_W-1:0]   pos_ext, pos_inc, len_ext, start_full;
    logic               letter_ok;
    logic               ring_wr;

    // slot that holds the letter entered pattern-length positions ago
    always_comb begin
        rd_sum = SUM_W'(ptr_reg) + SUM_W'(MAX_PATTERN) - SUM_W'(len_reg);
        if (rd_sum >= SUM_W'(MAX_PATTERN)) begin
            rd_sum = rd_sum - SUM_W'(MAX_PATTERN);
        end
        rd_addr = rd_sum[RING_AW-1:0];
    end

    always_comb begin
        pos_ext    = CMP_W'(pos_reg);
        pos_inc    = pos_ext + CMP_W'(1);
        len_ext    = CMP_W'(len_reg);
        start_full = pos_inc - len_ext;
        letter_ok  = 32'(letter) < 32'(ALPHABET);
    end

    always_comb begin
        pos_next  = pos_reg;
        len_next  = len_reg;
        ptr_next  = ptr_reg;
        ring_wr   = 1'b0;
        item_next = '0;
        item_next.op       = OP_NONE;
        item_next.letter   = letter;
        item_next.remove   = pos_ext >= len_ext;
        item_next.eligible = pos_inc >= len_ext;
        item_next.start    = MATCH_W'(start_full);
        if (accept) begin
            case (awm_mode_t'(mode))
                MODE_CLEAR: begin
                    pos_next     = '0;
                    len_next     = '0;
                    ptr_next     = '0;
                    item_next.op = OP_CLEAR;
                end
                MODE_PATTERN: begin
                    if (letter_ok && len_reg < LEN_W'(MAX_PATTERN) && pos_reg == '0) begin
                        len_next     = len_reg + LEN_W'(1);
                        item_next.op = OP_PATTERN;
                    end
                end
                MODE_TEXT: begin
                    if (letter_ok) begin
                        ring_wr = 1'b1;
                        if (ptr_reg == RING_AW'(MAX_PATTERN - 1)) begin
                            ptr_next = '0;
                        end else begin
                            ptr_next = ptr_reg + RING_AW'(1);
                        end
                        if (pos_reg != '1) begin
                            pos_next = pos_reg + POSITION_BITS'(1);
                        end
                        if (len_reg != '0) begin
                            item_next.op = OP_TEXT;
                        end
                    end
                end
                default: begin
                    item_next.op = OP_NONE;
                end
            endcase
        end
    end

    // ring: written and read at the same edge, read returns the prior contents
    always_ff @(posedge aclk) begin
        if (ring_wr) begin
            ring_mem[ptr_reg] <= letter;
        end
        if (advance) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            len_reg     <= '0;
            ptr_reg     <= '0;
            item_reg.op <= OP_NONE;
        end else if (advance) begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            ptr_reg  <= ptr_next;
            item_reg <= item_next;
        end
    end

    always_comb begin
        item_out            = item_reg;
        item_out.old_letter = rd_data_reg;
    end

endmodule

[hdl/awm_cell.sv]
// ----------------------------------------------------------------------------
// awm_cell: one letter of the alphabet
// Holds the pattern and window counts of its letter, updates them as an item
// passes and adds its change of the mismatch count to the item.
// ----------------------------------------------------------------------------
module awm_cell
    import awm_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 9
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  awm_item_t item_in,
    output awm_item_t item_out
);

    logic [CNT_W-1:0] pat_reg, pat_next;
    logic [CNT_W-1:0] win_reg, win_next;
    logic [CNT_W-1:0] win_dec;
    awm_item_t        item_reg, item_next;
    logic             hit, hit_old, diff_before, diff_after;

    always_comb begin
        hit      = 32'(item_in.letter) == 32'(IDX);
        hit_old  = item_in.remove && (32'(item_in.old_letter) == 32'(IDX));
        pat_next = pat_reg;
        win_next = win_reg;
        win_dec  = win_reg;
        case (item_in.op)
            OP_CLEAR: begin
                pat_next = '0;
                win_next = '0;
            end
            OP_PATTERN: begin
                if (hit) begin
                    pat_next = pat_reg + CNT_W'(1);
                end
            end
            OP_TEXT: begin
                if (hit_old && win_reg != '0) begin
                    win_dec = win_reg - CNT_W'(1);
                end
                win_next = hit ? win_dec + CNT_W'(1) : win_dec;
            end
            default: begin
                pat_next = pat_reg;
            end
        endcase
        diff_before     = pat_reg != win_reg;
        diff_after      = pat_next != win_next;
        item_next       = item_in;
        item_next.delta = item_in.delta + DELTA_W'(diff_after) - DELTA_W'(diff_before);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_reg     <= '0;
            win_reg     <= '0;
            item_reg.op <= OP_NONE;
        end else if (advance) begin
            pat_reg  <= pat_next;
            win_reg  <= win_next;
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

[hdl/awm_tail.sv]
// ----------------------------------------------------------------------------
// awm_tail: mismatch count, match decision and output skid buffer
// Sums the per-letter changes gathered along the chain and reports the window
// start when the window is full and no letter differs.
// ----------------------------------------------------------------------------
module awm_tail
    import awm_pkg::*;
#(
    parameter int ALPHABET = 26
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  awm_item_t          item_in,
    output logic               advance,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MATCH_W-1:0] m_tdata
);

    localparam int DIFF_W = $clog2(ALPHABET + 1);

    logic [DIFF_W-1:0]        diff_reg, diff_next;
    logic signed [DIFF_W+1:0] diff_sum;
    logic                     res;
    logic                     out_valid_reg, out_valid_next;
    logic                     skid_valid_reg, skid_valid_next;
    logic [MATCH_W-1:0]       out_data_reg, out_data_next;
    logic [MATCH_W-1:0]       skid_data_reg, skid_data_next;

    assign advance = !skid_valid_reg;

    always_comb begin
        diff_sum  = $signed({2'b00, diff_reg}) + (DIFF_W+2)'(item_in.delta);
        diff_next = diff_reg;
        case (item_in.op)
            OP_CLEAR:   diff_next = '0;
            OP_PATTERN: diff_next = diff_sum[DIFF_W-1:0];
            OP_TEXT:    diff_next = diff_sum[DIFF_W-1:0];
            default:    diff_next = diff_reg;
        endcase
        res = advance && item_in.op == OP_TEXT && item_in.eligible
              && diff_sum[DIFF_W-1:0] == '0;
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = res;
                out_data_next  = item_in.start;
            end
        end else if (res) begin
            skid_valid_next = 1'b1;
            skid_data_next  = item_in.start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                diff_reg <= diff_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[hdl/anagram_window_matcher.sv]
// an accepted text item passes the head register, every cell register and the tail output register before m_tvalid
// throughput: one item per cycle while the chain is not stopped, every stage moves in lockstep
// the chain stops only while both output slots hold results not yet taken
// reset: counts, pattern length, position, ring pointer and output cleared at once
// reset: the ring of recent letters is not cleared, no clearing pass
// ----------------------------------------------------------------------------
// anagram_window_matcher: streaming sliding-window anagram search
// Pattern letters build a histogram, text letters slide a window of pattern
// length over the text; a match reports the start position of the window.
// ----------------------------------------------------------------------------
module anagram_window_matcher
    import awm_pkg::*;
#(
    parameter int MAX_PATTERN   = 256,
    parameter int ALPHABET      = 26,
    parameter int POSITION_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // mode [1:0], letter [6:2], zero [7]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [MATCH_W-1:0]  m_tdata    // match_start [31:0]
);

    // counts never exceed the pattern length
    localparam int CNT_W = $clog2(MAX_PATTERN + 1);

    logic      advance;
    logic      accept;
    awm_item_t chain [0:ALPHABET];

    // ready only depends on the skid register, so no path from m_tready
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    // head: decode, length and position, ring read of the leaving letter
    awm_head #(
        .MAX_PATTERN   (MAX_PATTERN),
        .ALPHABET      (ALPHABET),
        .POSITION_BITS (POSITION_BITS)
    ) u_head (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .advance  (advance),
        .mode     (s_tdata[1:0]),
        .letter   (s_tdata[6:2]),
        .item_out (chain[0])
    );

    // one cell per letter; each item visits every cell in order, so a later
    // item always sees the counts that earlier items left behind
    for (genvar k = 0; k < ALPHABET; k++) begin : g_cell
        awm_cell #(
            .IDX   (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .item_in  (chain[k]),
            .item_out (chain[k+1])
        );
    end

    // tail: running mismatch count and output register with skid slot
    awm_tail #(
        .ALPHABET (ALPHABET)
    ) u_tail (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item_in  (chain[ALPHABET]),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[hdl/awm_checker.sv]
// ----------------------------------------------------------------------------
// awm_checker: port-level checks for the anagram window matcher
// Watches the handshakes on both channels and the reset behavior.
// ----------------------------------------------------------------------------
module awm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // input is refused only while a result waits on the output
    a_ready_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input refused with output empty");

    // reset leaves no result and an open input
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("bad state after reset");

endmodule

bind anagram_window_matcher awm_checker u_awm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[dv/tb_anagram_window_matcher.sv]
// ----------------------------------------------------------------------------
// tb_anagram_window_matcher: self-checking bench for the anagram matcher
// Drives mode/letter items on the input stream, predicts every match start
// with a scoreboard that keeps its own pattern and window histograms, and
// compares each result item in order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_anagram_window_matcher
    import awm_pkg::*;
();

    localparam int MAX_PATTERN     = 256;
    localparam int ALPHABET        = 26;
    localparam int POSITION_BITS   = 32;
    localparam int RANDOM_ITEMS    = 1900;
    localparam int PRESSURE_CYCLES = 500;
    localparam int DRAIN_CYCLES    = ALPHABET + 2 + 100;
    localparam int WATCHDOG_LIMIT  = 4000;

    // mode 3 has no name in the package, the block ignores it
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;   // mode [1:0], letter [6:2], zero [7]
    logic               m_tvalid;
    logic               m_tready;
    logic [MATCH_W-1:0] m_tdata;   // match_start [31:0]

    // ------------------------------------------------------------------------
    // scoreboard: histogram predictor plus queue of expected match starts
    // ------------------------------------------------------------------------
    class match_scoreboard;
        logic [8:0]               pat_hist[ALPHABET];
        logic [8:0]               win_hist[ALPHABET];
        logic [4:0]               n_diff;
        logic [8:0]               pat_len;
        logic [POSITION_BITS-1:0] text_pos;
        logic [LETTER_W-1:0]      ring[MAX_PATTERN];
        logic [7:0]               ring_ptr;
        logic [MATCH_W-1:0]       expected_starts[$];
        int errors;
        int matches_seen;
        int pattern_items;
        int text_items;
        int clear_items;
        int ignored_items;

        function new();
            foreach (ring[i]) ring[i] = '0;
            clear_all();
        endfunction

        function void clear_all();
            foreach (pat_hist[i]) begin
                pat_hist[i] = '0;
                win_hist[i] = '0;
            end
            n_diff   = '0;
            pat_len  = '0;
            text_pos = '0;
            ring_ptr = '0;
        endfunction

        // keep the count of differing letters in step with one count change
        function void shift_count(bit pattern_side, logic [LETTER_W-1:0] c, bit grow);
            if (pat_hist[c] != win_hist[c]) n_diff--;
            if (pattern_side) pat_hist[c]++;
            else if (grow) win_hist[c]++;
            else win_hist[c]--;
            if (pat_hist[c] != win_hist[c]) n_diff++;
        endfunction

        function void note_item(logic [MODE_W-1:0] mode, logic [LETTER_W-1:0] c);
            logic [POSITION_BITS-1:0] pos;
            logic [7:0]               slot;
            logic [LETTER_W-1:0]      old;
            logic [POSITION_BITS:0]   span_end;
            logic [POSITION_BITS:0]   start;
            if (mode == MODE_CLEAR) begin
                clear_all();
                clear_items++;
                return;
            end
            if (mode == MODE_UNUSED || c >= ALPHABET) begin
                ignored_items++;
                return;
            end
            if (mode == MODE_PATTERN) begin
                // pattern is frozen once full or once text has started
                if (pat_len >= MAX_PATTERN || text_pos != 0) begin
                    ignored_items++;
                    return;
                end
                shift_count(1'b1, c, 1'b1);
                pat_len++;
                pattern_items++;
                return;
            end
            text_items++;
            pos = text_pos;
            if (pat_len != 0) begin
                if (pos >= pat_len) begin
                    // letter that entered pattern-length items ago leaves
                    slot = ring_ptr - pat_len[7:0];
                    old  = ring[slot];
                    if (old < ALPHABET && win_hist[old] != 0) shift_count(1'b0, old, 1'b0);
                end
                shift_count(1'b0, c, 1'b1);
            end
            ring[ring_ptr] = c;
            ring_ptr++;
            if (text_pos != '1) text_pos++;
            span_end = {1'b0, pos} + 1'b1;
            if (pat_len != 0 && n_diff == 0 && span_end >= pat_len) begin
                start = span_end - pat_len;
                expected_starts.insert(expected_starts.size(), start[MATCH_W-1:0]);
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] mismatch %0d: %s", $time, errors, what);
        endtask

        task check_match(logic [MATCH_W-1:0] got);
            logic [MATCH_W-1:0] want;
            matches_seen++;
            if (expected_starts.size() == 0) begin
                report_mismatch($sformatf("unexpected match_start %0d", got));
                return;
            end
            want = expected_starts.pop_front();
            if (got !== want)
                report_mismatch($sformatf("match_start %0d, expected %0d", got, want));
        endtask
    endclass

    match_scoreboard sb;

    // sender and receiver controls
    bit  burst_mode;              // sender offers back to back
    bit  hold_req;                // ask the receiver for one long hold-off
    int  sent_items;              // clears, and items of a named mode with a letter in range
    int  idle_cycles;
    int  input_stall_cycles;
    logic [LETTER_W-1:0] word_letters[$];   // letters of the current pattern

    anagram_window_matcher #(
        .MAX_PATTERN   (MAX_PATTERN),
        .ALPHABET      (ALPHABET),
        .POSITION_BITS (POSITION_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // starts and ends at a falling edge; valid stays high between back to back items
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [LETTER_W-1:0] letter);
        int gap;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, letter, mode};
        do @(posedge aclk); while (!s_tready);
        if (mode != MODE_UNUSED && (mode == MODE_CLEAR || letter < ALPHABET)) sent_items++;
        @(negedge aclk);
    endtask

    // pattern letters drawn from a narrow band so text matches often
    task automatic send_pattern_word(input int len, input int span);
        int base;
        logic [LETTER_W-1:0] c;
        word_letters.delete();
        base = $urandom_range(0, ALPHABET - span);
        repeat (len) begin
            c = LETTER_W'(base + $urandom_range(0, span - 1));
            word_letters.insert(word_letters.size(), c);
            send_item(MODE_PATTERN, c);
        end
    endtask

    // text mostly from the pattern's letters, some strays and a little noise
    task automatic send_text_run(input int len, input int stray_pct);
        logic [LETTER_W-1:0] c;
        repeat (len) begin
            if (word_letters.size() == 0 || $urandom_range(0, 99) < stray_pct)
                c = LETTER_W'($urandom_range(0, ALPHABET - 1));
            else
                c = word_letters[$urandom_range(0, word_letters.size() - 1)];
            if ($urandom_range(0, 99) < 3)
                send_item(MODE_TEXT, LETTER_W'($urandom_range(ALPHABET, 31)));
            else if ($urandom_range(0, 99) < 2)
                send_item(MODE_UNUSED, LETTER_W'($urandom_range(0, 31)));
            send_item(MODE_TEXT, c);
        end
    endtask

    // ------------------------------------------------------------------------
    // monitor: input items feed the predictor, result items are checked
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_item(s_tdata[1:0], s_tdata[6:2]);
            if (m_tvalid && m_tready) sb.check_match(m_tdata);
            if (s_tvalid && !s_tready) input_stall_cycles <= input_stall_cycles + 1;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog: nothing moved on either side for too long
    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("no item moved for %0d cycles, %0d matches still expected",
                 idle_cycles, sb.expected_starts.size());
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: random ready, free runs, and one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : receiver
        int hold_left;
        int free_left;
        int stall_left;
        m_tready   = 1'b0;
        hold_left  = 0;
        free_left  = 0;
        stall_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = PRESSURE_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (free_left > 0) begin
                m_tready <= 1'b1;
                free_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                // some runs are long stretches with no idling at all
                free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 30);
                stall_left = pick_gap();
                m_tready <= 1'b1;
                free_left--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int seq_n;
        int kind;
        int len;
        sb         = new();
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        burst_mode = 1'b0;
        hold_req   = 1'b0;
        sent_items = 0;
        idle_cycles        = 0;
        input_stall_cycles = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty pattern: text counts in position but never matches
        send_item(MODE_TEXT, 5'd0);
        send_item(MODE_PATTERN, 5'd0);      // too late, text already seen
        send_item(MODE_CLEAR, 5'd31);       // letter field is don't care here
        // unused mode and out-of-range letters are dropped
        send_item(MODE_UNUSED, 5'd0);
        send_item(MODE_PATTERN, 5'd31);
        send_item(MODE_PATTERN, 5'd0);      // a
        send_item(MODE_PATTERN, 5'd25);     // z
        send_item(MODE_TEXT, 5'd26);
        send_item(MODE_TEXT, 5'd30);
        send_item(MODE_TEXT, 5'd25);        // z, window not full
        send_item(MODE_TEXT, 5'd0);         // a, match at 0
        send_item(MODE_TEXT, 5'd25);        // z, match at 1
        send_item(MODE_PATTERN, 5'd1);      // ignored, pattern frozen
        send_item(MODE_TEXT, 5'd1);
        send_item(MODE_TEXT, 5'd0);
        send_item(MODE_TEXT, 5'd25);        // match at 4
        send_item(MODE_UNUSED, 5'd31);
        // repeated letters in the pattern
        send_item(MODE_CLEAR, 5'd0);
        send_item(MODE_PATTERN, 5'd7);
        send_item(MODE_PATTERN, 5'd7);
        send_item(MODE_TEXT, 5'd7);
        send_item(MODE_TEXT, 5'd7);         // match at 0
        send_item(MODE_TEXT, 5'd7);         // match at 1
        send_item(MODE_TEXT, 5'd31);

        seq_n = 0;
        while (sent_items < RANDOM_ITEMS + 20) begin
            seq_n++;
            burst_mode = ($urandom_range(0, 3) == 0);
            if (seq_n == 3) begin
                // receiver holds off while every text item matches
                send_item(MODE_CLEAR, LETTER_W'($urandom_range(0, 31)));
                send_pattern_word(1, 1);
                hold_req   = 1'b1;
                burst_mode = 1'b1;
                send_text_run(80, 0);
            end else if (seq_n == 8 || $urandom_range(0, 99) < 2) begin
                // full pattern with overflow letters, text repeats its first
                // MAX_PATTERN letters so every full window is an anagram
                send_item(MODE_CLEAR, LETTER_W'($urandom_range(0, 31)));
                send_pattern_word(MAX_PATTERN + $urandom_range(0, 6), 4);
                len = MAX_PATTERN + $urandom_range(10, 50);
                for (int i = 0; i < len; i++)
                    send_item(MODE_TEXT, word_letters[i % MAX_PATTERN]);
            end else begin
                kind = $urandom_range(0, 99);
                if (kind < 70) begin
                    send_item(MODE_CLEAR, LETTER_W'($urandom_range(0, 31)));
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                      : $urandom_range(1, 6);
                    send_pattern_word(len, $urandom_range(1, 4));
                    send_text_run($urandom_range(10, 60), 5);
                end else if (kind < 85) begin
                    // raw noise over every mode and letter value
                    repeat ($urandom_range(10, 30))
                        send_item(MODE_W'($urandom_range(0, 3)),
                                  LETTER_W'($urandom_range(0, 31)));
                end else begin
                    send_item(MODE_CLEAR, LETTER_W'($urandom_range(0, 31)));
                    case ($urandom_range(0, 2))
                        0: begin
                            // text before any pattern, late pattern is dropped
                            word_letters.delete();
                            send_text_run($urandom_range(3, 12), 0);
                            send_pattern_word($urandom_range(1, 4), 3);
                            send_text_run($urandom_range(5, 15), 5);
                        end
                        1: begin
                            // pattern letters sneaking in mid-text
                            send_pattern_word($urandom_range(1, 5), 3);
                            send_text_run($urandom_range(5, 20), 5);
                            repeat ($urandom_range(1, 3))
                                send_item(MODE_PATTERN,
                                          LETTER_W'($urandom_range(0, ALPHABET - 1)));
                            send_text_run($urandom_range(5, 20), 5);
                        end
                        default: begin
                            // clear in the middle of the text
                            send_pattern_word($urandom_range(1, 5), 2);
                            send_text_run($urandom_range(5, 20), 5);
                            send_item(MODE_CLEAR, LETTER_W'($urandom_range(0, 31)));
                            send_text_run($urandom_range(3, 10), 5);
                        end
                    endcase
                end
            end
        end
        s_tvalid <= 1'b0;

        while (sb.expected_starts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d pattern, %0d text, %0d clear and %0d ignored items",
                 sb.pattern_items, sb.text_items, sb.clear_items, sb.ignored_items);
        $display("%0d match starts compared, input stalled for %0d cycles, %0d mismatches",
                 sb.matches_seen, input_stall_cycles, sb.errors);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
